@@ design/fire_heat_diffusion_renderer_top_macros.svh @@
// ---------------------------------------------------------------------------
// Fire heat diffusion renderer assertion macros
// Shared property wrappers for the checker.
// ---------------------------------------------------------------------------
`ifndef FIRE_HEAT_DIFFUSION_RENDERER_TOP_MACROS_SVH
`define FIRE_HEAT_DIFFUSION_RENDERER_TOP_MACROS_SVH

// Property checked outside reset.
`define FHD_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked also across reset.
`define FHD_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/fhd_pkg.sv @@
// ---------------------------------------------------------------------------
// Fire heat diffusion package
// Types, codes, sizes and the pen table shared by the design.
// ---------------------------------------------------------------------------
package fhd_pkg;

  localparam int COLUMNS_DEF        = 53;
  localparam int ROWS_DEF           = 12;
  localparam int HEAT_FRAC_BITS_DEF = 8;

  localparam int CELL_W = 9;
  localparam int IDX_W  = 3;

  localparam logic [1:0] OP_ROW   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_SEED  = 2'd2;

  localparam logic [IDX_W-1:0] REG_HOT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_WARM  = 3'd1;
  localparam logic [IDX_W-1:0] REG_EMBER = 3'd2;
  localparam logic [IDX_W-1:0] REG_SMOKE = 3'd3;
  localparam logic [IDX_W-1:0] REG_DECAY = 3'd4;
  localparam logic [IDX_W-1:0] REG_SEED  = 3'd5;

  localparam logic [2:0] LVL_BLACK = 3'd0;
  localparam logic [2:0] LVL_HOT   = 3'd1;
  localparam logic [2:0] LVL_WARM  = 3'd2;
  localparam logic [2:0] LVL_EMBER = 3'd3;
  localparam logic [2:0] LVL_SMOKE = 3'd4;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] row_index;
    logic [5:0] seed_position;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  column;
    logic [3:0]  line;
    logic [2:0]  color_level;
    logic [23:0] pixel_rgb;
    logic        last_in_row;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic load;
  } cell_ctrl_t;

  function automatic logic [23:0] pen_rgb(input logic [2:0] lvl);
    logic [23:0] pen;
    case (lvl)
      LVL_HOT:   pen = 24'hFFFFB4;
      LVL_WARM:  pen = 24'hDCA000;
      LVL_EMBER: pen = 24'hB43200;
      LVL_SMOKE: pen = 24'h282828;
      default:   pen = 24'h000000;
    endcase
    return pen;
  endfunction

endpackage

@@ design/fhd_cell.sv @@
// ---------------------------------------------------------------------------
// Fire heat diffusion cell
// One heat cell of a row chain: clear, load or take the neighbor's value.
// ---------------------------------------------------------------------------
module fhd_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  fhd_pkg::cell_ctrl_t           ctrl,
  input  logic [fhd_pkg::CELL_W-1:0]    shift_in,
  input  logic [fhd_pkg::CELL_W-1:0]    load_value,
  output logic [fhd_pkg::CELL_W-1:0]    q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (ctrl.clear) begin
      q <= '0;
    end else if (ctrl.load) begin
      q <= load_value;
    end else if (ctrl.shift) begin
      q <= shift_in;
    end
  end

endmodule

@@ design/fire_heat_diffusion_renderer_top.sv @@
// A row item holds the input stalled until its last column is stepped, one column
// per cycle as the row chains rotate by one cell; after acceptance the busy flag
// is set, then each step registers a result, and output stalls hold the chains.
// Clear and seed items are applied on acceptance and give no result.
// Synchronous reset clears the whole heat map and loads the default levels.
// ---------------------------------------------------------------------------
// Fire heat diffusion renderer top level
// Heat map held as rotating row chains of cells, with render and averaging.
// ---------------------------------------------------------------------------
module fire_heat_diffusion_renderer_top #(
  parameter int COLUMNS        = fhd_pkg::COLUMNS_DEF,
  parameter int ROWS           = fhd_pkg::ROWS_DEF,
  parameter int HEAT_FRAC_BITS = fhd_pkg::HEAT_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [fhd_pkg::IDX_W-1:0]     cfg_index,
  input  logic [fhd_pkg::CELL_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fhd_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fhd_pkg::out_item_t            out_item
);

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS + 1);
  localparam int W  = fhd_pkg::CELL_W;

  localparam int HOT_RST   = (((5 << HEAT_FRAC_BITS) * 2 + 10) / 20) & 511;
  localparam int WARM_RST  = (((4 << HEAT_FRAC_BITS) * 2 + 10) / 20) & 511;
  localparam int EMBER_RST = (((3 << HEAT_FRAC_BITS) * 2 + 10) / 20) & 511;
  localparam int SMOKE_RST = (((2 << HEAT_FRAC_BITS) * 2 + 10) / 20) & 511;
  localparam int DECAY_RST = (((1 << HEAT_FRAC_BITS) * 2 + 100) / 200) & 511;
  localparam int SEED_RST  = (1 << HEAT_FRAC_BITS) & 511;

  logic [W-1:0] hot_level, warm_level, ember_level, smoke_level;
  logic [W-1:0] decay_amount, seed_heat;

  always_ff @(posedge clk) begin
    if (rst) begin
      hot_level    <= W'(HOT_RST);
      warm_level   <= W'(WARM_RST);
      ember_level  <= W'(EMBER_RST);
      smoke_level  <= W'(SMOKE_RST);
      decay_amount <= W'(DECAY_RST);
      seed_heat    <= W'(SEED_RST);
    end else if (cfg_write) begin
      case (cfg_index)
        fhd_pkg::REG_HOT:   hot_level    <= cfg_data;
        fhd_pkg::REG_WARM:  warm_level   <= cfg_data;
        fhd_pkg::REG_EMBER: ember_level  <= cfg_data;
        fhd_pkg::REG_SMOKE: smoke_level  <= cfg_data;
        fhd_pkg::REG_DECAY: decay_amount <= cfg_data;
        fhd_pkg::REG_SEED:  seed_heat    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  logic          busy;
  logic [CW-1:0] col;
  logic [RW-1:0] cur_row;
  logic          accept, step, last_col;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign step     = busy && (!out_valid || !out_stall);
  assign last_col = (col == CW'(COLUMNS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      col  <= '0;
    end else if (accept) begin
      if (in_item.op == fhd_pkg::OP_ROW && int'(in_item.row_index) < ROWS) begin
        busy <= 1'b1;
      end
      col <= '0;
    end else if (step) begin
      col <= last_col ? '0 : col + 1'b1;
      if (last_col) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_row <= RW'(in_item.row_index);
    end
  end

  // Heat map as rotating row chains
  logic [W-1:0] cell_q [ROWS+1][COLUMNS];
  logic [W-1:0] head0 [ROWS+1];
  logic [W-1:0] head1 [ROWS+1];
  logic [W-1:0] tailq [ROWS+1];
  logic [RW:0]  row1, row2;
  logic [W-1:0] new_val;

  assign row1 = {1'b0, cur_row} + 1'b1;
  assign row2 = {1'b0, cur_row} + 2'd2;

  genvar gr, gc;
  generate
    for (gr = 0; gr <= ROWS; gr++) begin : g_row
      logic row_shift;
      assign row_shift = step && ((gr == int'(cur_row)) || (gr == int'(row1)) ||
                                  (gr == int'(row2)));
      assign head0[gr] = cell_q[gr][0];
      assign head1[gr] = cell_q[gr][1];
      assign tailq[gr] = cell_q[gr][COLUMNS-1];
      for (gc = 0; gc < COLUMNS; gc++) begin : g_col
        fhd_pkg::cell_ctrl_t ctrl;
        logic [W-1:0]        sin;
        if (gc == COLUMNS - 1) begin : g_tail
          // The row under update takes the averaged value; the rows below wrap around.
          assign sin = (gr == int'(cur_row)) ? new_val : cell_q[gr][0];
        end else begin : g_body
          assign sin = cell_q[gr][gc+1];
        end
        assign ctrl.shift = row_shift;
        assign ctrl.clear = accept && (in_item.op == fhd_pkg::OP_CLEAR) && (gr == ROWS - 1);
        assign ctrl.load  = accept && (in_item.op == fhd_pkg::OP_SEED) &&
                            (gr >= ROWS - 1) &&
                            (gc + 1 >= int'(in_item.seed_position)) &&
                            (gc <= int'(in_item.seed_position) + 1);
        fhd_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .ctrl       (ctrl),
          .shift_in   (sin),
          .load_value (seed_heat),
          .q          (cell_q[gr][gc])
        );
      end
    end
  endgenerate

  // Averaging over the heads of the three chains
  logic [W-1:0]  h_self, h_below1, h_below2, h_left, h_right;
  logic [11:0]   sum;
  logic [23:0]   prod5;
  logic [9:0]    avg;
  logic [2:0]    lvl;

  always_comb begin
    h_self   = head0[cur_row];
    h_below1 = head0[RW'(row1)];
    h_below2 = (int'(row2) <= ROWS) ? head0[RW'(row2)] : '0;
    h_left   = (col == '0) ? '0 : tailq[RW'(row1)];
    h_right  = last_col ? '0 : head1[RW'(row1)];
    sum = 12'(h_self) + 12'(h_below1) + 12'(h_below2) + 12'(h_left) + 12'(h_right);
    // Divide by five through a reciprocal, exact for sums below 2^14
    prod5 = sum * 12'd3277;
    if (col == '0 || last_col) begin
      avg = 10'(sum >> 2);
    end else begin
      avg = 10'(prod5 >> 14);
    end
    new_val = (avg > 10'(decay_amount)) ? W'(avg - 10'(decay_amount)) : '0;

    if (h_self > hot_level) begin
      lvl = fhd_pkg::LVL_HOT;
    end else if (h_self > warm_level) begin
      lvl = fhd_pkg::LVL_WARM;
    end else if (h_self > ember_level) begin
      lvl = fhd_pkg::LVL_EMBER;
    end else if (h_self > smoke_level) begin
      lvl = fhd_pkg::LVL_SMOKE;
    end else begin
      lvl = fhd_pkg::LVL_BLACK;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item.column      <= 6'(col);
      out_item.line        <= 4'(cur_row);
      out_item.color_level <= lvl;
      out_item.pixel_rgb   <= fhd_pkg::pen_rgb(lvl);
      out_item.last_in_row <= last_col;
    end
  end

endmodule

@@ design/fhd_checker.sv @@
// ---------------------------------------------------------------------------
// Fire heat diffusion port checker
// Watches the top level's ports for ordering and handshake slips.
// ---------------------------------------------------------------------------
`include "fire_heat_diffusion_renderer_top_macros.svh"

module fhd_port_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input fhd_pkg::out_item_t out_item
);

  `FHD_CHECK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_item), "result changed while stalled")
  `FHD_CHECK(a_busy_in_row, out_valid && !out_item.last_in_row |-> in_stall, "input taken in the middle of a row")
  `FHD_CHECK(a_col_advance, out_valid && !out_stall && !out_item.last_in_row |=> out_valid && out_item.column == $past(out_item.column) + 6'd1, "columns not consecutive")
  `FHD_CHECK_ALWAYS(a_reset_idle, rst |=> !out_valid && !in_stall, "not idle after reset")

endmodule

bind fire_heat_diffusion_renderer_top fhd_port_checker u_fhd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
